### hw/rtl/hbis_pkg.sv
// Package for the hierarchical bitmap integer set.
// Holds the sizes, the action codes and the word types of both channels.
// Depends on nothing.
`timescale 1ns / 1ps

package hbis_pkg;

    localparam int KEY_W       = 12;
    localparam int WORD_BITS   = 64;
    localparam int WORD_COUNT  = 64;
    localparam int TREE_LEAVES = 64;
    localparam int WORD_IDX_W  = 6;
    localparam int BIT_IDX_W   = 6;
    localparam int NODE_W      = 7;
    localparam int TREE_NODES  = 2 * TREE_LEAVES;
    localparam int GROUP_W     = 8;
    localparam int GROUP_CNT   = WORD_BITS / GROUP_W;
    localparam int GROUP_IDX_W = 3;
    localparam int GBIT_IDX_W  = 3;

    typedef enum logic [2:0] {
        ACT_INSERT     = 3'd0,
        ACT_ERASE      = 3'd1,
        ACT_TEST       = 3'd2,
        ACT_NEXT_AT    = 3'd3,
        ACT_NEXT_ABOVE = 3'd4,
        ACT_PREV_AT    = 3'd5,
        ACT_PREV_BELOW = 3'd6,
        ACT_CLEAR      = 3'd7
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   result_key;
        logic               set_nonempty;
    } rsp_word_t;

endpackage

### hw/rtl/hbis_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no package dependency.
`timescale 1ns / 1ps

module hbis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/hierarchical_bitmap_integer_set.sv
// Top level of the hierarchical bitmap integer set.
// Uses hbis_pkg and one hbis_ram instance for the member words.
//
// Requests enter on s_valid/s_ready/s_data, one word holding an action and a key.
// Every request produces exactly one result word on m_valid/m_ready/m_data,
// carrying the found flag, the key found by a search and the non-empty flag.
// Membership lives in a 64 x 64-bit RAM with a registered read port. A
// per-word non-empty flag register qualifies each RAM word, so a word never
// written, or emptied, reads as zero; the summary tree is the OR tree of these
// flags. Requests are handled one at a time. Insert, erase, test and clear
// are evaluated in ST_EVAL and go straight to ST_DONE. A search that hits in
// its own word scans it by byte group and then by bit. Otherwise the search
// climbs the tree to a sibling with members, descends to its leaf word, reads
// that word from the RAM and scans it the same way; a search that finds
// nothing stops at the root. The walk is one tree level per cycle.
// The output register frees the block to accept the next request while a
// result waits; if the receiver stalls, the following result holds until the
// register empties. Reset empties the set at once, with no clearing pass.
`timescale 1ns / 1ps

module hierarchical_bitmap_integer_set (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hbis_pkg::req_word_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hbis_pkg::rsp_word_t m_data
);

    import hbis_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLIMB,
        ST_DESCEND,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN_GRP,
        ST_SCAN_BIT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    action_t                act_reg;
    logic [BIT_IDX_W-1:0]   bit_reg;
    logic [WORD_IDX_W-1:0]  word_reg;
    logic [NODE_W-1:0]      node_reg;
    logic [WORD_COUNT-1:0]  nz_reg;
    logic [WORD_BITS-1:0]   scan_reg;
    logic [GROUP_IDX_W-1:0] grp_reg;
    logic [GROUP_W-1:0]     byte_reg;
    logic                   found_reg;
    logic [KEY_W-1:0]       res_reg;
    logic                   m_valid_reg;
    rsp_word_t              m_data_reg;

    logic [TREE_NODES-1:0]  tree;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_we;
    logic [WORD_IDX_W-1:0]  ram_raddr;
    logic [WORD_BITS-1:0]   word_data;
    logic [WORD_BITS-1:0]   key_onehot;
    logic [WORD_BITS-1:0]   mask_at;
    logic [WORD_BITS-1:0]   mask_above;
    logic [WORD_BITS-1:0]   own_bits;
    logic [WORD_BITS-1:0]   erased_data;
    logic                   upward;
    logic                   strict;
    logic [NODE_W-1:0]      sib_node;
    logic [NODE_W-1:0]      child_node;
    logic [GROUP_CNT-1:0]   grp_any;
    logic [GROUP_IDX_W-1:0] grp_idx;
    logic [GROUP_W-1:0]     grp_byte;
    logic [GBIT_IDX_W-1:0]  gbit_idx;
    logic                   out_load;

    always_comb begin
        tree = '0;
        for (int i = 0; i < TREE_LEAVES; i++) begin
            tree[TREE_LEAVES + i] = nz_reg[i];
        end
        for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
            tree[n] = tree[2 * n] | tree[2 * n + 1];
        end
    end

    assign word_data   = nz_reg[word_reg] ? ram_rdata : '0;
    assign key_onehot  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;
    assign mask_at     = {WORD_BITS{1'b1}} << bit_reg;
    assign mask_above  = mask_at << 1;
    assign erased_data = word_data & ~key_onehot;
    assign upward      = (act_reg == ACT_NEXT_AT) || (act_reg == ACT_NEXT_ABOVE);
    assign strict      = (act_reg == ACT_NEXT_ABOVE) || (act_reg == ACT_PREV_BELOW);

    always_comb begin
        if (upward) begin
            own_bits = word_data & (strict ? mask_above : mask_at);
        end else begin
            own_bits = word_data & ~(strict ? mask_at : mask_above);
        end
    end

    assign sib_node   = node_reg ^ {{(NODE_W-1){1'b0}}, 1'b1};
    assign child_node = {node_reg[NODE_W-2:0], 1'b0};

    always_comb begin
        for (int i = 0; i < GROUP_CNT; i++) begin
            grp_any[i] = |scan_reg[i*GROUP_W +: GROUP_W];
        end
        grp_idx = '0;
        if (upward) begin
            for (int i = GROUP_CNT - 1; i >= 0; i--) begin
                if (grp_any[i]) begin
                    grp_idx = GROUP_IDX_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < GROUP_CNT; i++) begin
                if (grp_any[i]) begin
                    grp_idx = GROUP_IDX_W'(i);
                end
            end
        end
        grp_byte = scan_reg[{grp_idx, {GBIT_IDX_W{1'b0}}} +: GROUP_W];
    end

    always_comb begin
        gbit_idx = '0;
        if (upward) begin
            for (int i = GROUP_W - 1; i >= 0; i--) begin
                if (byte_reg[i]) begin
                    gbit_idx = GBIT_IDX_W'(i);
                end
            end
        end else begin
            for (int i = 0; i < GROUP_W; i++) begin
                if (byte_reg[i]) begin
                    gbit_idx = GBIT_IDX_W'(i);
                end
            end
        end
    end

    assign ram_we    = (state_reg == ST_EVAL)
                       && ((act_reg == ACT_INSERT) || (act_reg == ACT_ERASE));
    assign ram_wdata = (act_reg == ACT_INSERT) ? (word_data | key_onehot) : erased_data;
    assign ram_raddr = (state_reg == ST_IDLE) ? s_data.key[KEY_W-1:BIT_IDX_W] : word_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    hbis_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nz_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_data.action;
                        word_reg  <= s_data.key[KEY_W-1:BIT_IDX_W];
                        bit_reg   <= s_data.key[BIT_IDX_W-1:0];
                        found_reg <= 1'b0;
                        res_reg   <= '0;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    unique case (act_reg)
                        ACT_INSERT: begin
                            nz_reg[word_reg] <= 1'b1;
                            state_reg        <= ST_DONE;
                        end
                        ACT_ERASE: begin
                            nz_reg[word_reg] <= |erased_data;
                            state_reg        <= ST_DONE;
                        end
                        ACT_TEST: begin
                            found_reg <= word_data[bit_reg];
                            state_reg <= ST_DONE;
                        end
                        ACT_NEXT_AT, ACT_NEXT_ABOVE, ACT_PREV_AT, ACT_PREV_BELOW: begin
                            if (|own_bits) begin
                                scan_reg  <= own_bits;
                                state_reg <= ST_SCAN_GRP;
                            end else begin
                                node_reg  <= {1'b1, word_reg};
                                state_reg <= ST_CLIMB;
                            end
                        end
                        ACT_CLEAR: begin
                            nz_reg    <= '0;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_CLIMB: begin
                    priority if (node_reg <= NODE_W'(1)) begin
                        state_reg <= ST_DONE;
                    end else if ((upward != node_reg[0]) && tree[sib_node]) begin
                        node_reg  <= sib_node;
                        state_reg <= ST_DESCEND;
                    end else begin
                        node_reg <= node_reg >> 1;
                    end
                end
                ST_DESCEND: begin
                    if (node_reg[NODE_W-1]) begin
                        word_reg  <= node_reg[WORD_IDX_W-1:0];
                        state_reg <= ST_FETCH;
                    end else if (upward) begin
                        node_reg <= tree[child_node] ? child_node : (child_node | NODE_W'(1));
                    end else begin
                        node_reg <= tree[child_node | NODE_W'(1)]
                                    ? (child_node | NODE_W'(1)) : child_node;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    scan_reg  <= ram_rdata;
                    state_reg <= ST_SCAN_GRP;
                end
                ST_SCAN_GRP: begin
                    grp_reg   <= grp_idx;
                    byte_reg  <= grp_byte;
                    state_reg <= ST_SCAN_BIT;
                end
                ST_SCAN_BIT: begin
                    found_reg <= 1'b1;
                    res_reg   <= {word_reg, grp_reg, gbit_idx};
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_data_reg.found        <= found_reg;
                        m_data_reg.result_key   <= res_reg;
                        m_data_reg.set_nonempty <= |nz_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
